// ----- design/ttc_pkg.sv -----
// Shared types and constants for the triggered trace capture unit.
package ttc_pkg;

	localparam int unsigned TTC_DEPTH = 128;
	localparam int unsigned TTC_AW    = $clog2(TTC_DEPTH);
	localparam int unsigned TTC_CW    = $clog2(TTC_DEPTH + 1);
	localparam int unsigned TTC_DW    = 10;
	localparam int unsigned TTC_IW    = 8;
	localparam int unsigned TTC_PW    = 8;
	localparam int unsigned TTC_IN_TW  = 24;
	localparam int unsigned TTC_OUT_TW = 24;
	localparam int unsigned TTC_PAW   = 3;

	localparam logic [TTC_PW-1:0] TTC_PTS_RESET = 8'd50;
	localparam logic [TTC_PAW-1:0] TTC_ADDR_PTS = 3'd0;

	typedef enum logic [1:0] {
		ACT_ARM     = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_TRIGGER = 2'd2,
		ACT_READ    = 2'd3
	} ttc_action_t;

	typedef struct packed {
		logic              valid;
		logic              is_read;
		logic              done;
		logic              at_trig;
		logic              past_end;
		logic [TTC_CW-1:0] held;
		logic              trig;
	} ttc_stage_t;

endpackage

// ----- design/ttc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module ttc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/ttc_ctrl.sv -----
// Capture control: pointers, counts, store addressing and the first pipeline stage.
module ttc_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  ttc_pkg::ttc_action_t            action,
	input  logic [ttc_pkg::TTC_DW-1:0]      sample_value,
	input  logic [ttc_pkg::TTC_IW-1:0]      read_index,
	input  logic [ttc_pkg::TTC_PW-1:0]      post_trigger_samples,
	input  logic                            take_s1,
	output ttc_pkg::ttc_stage_t             stage_s1,
	output logic                            wr_en,
	output logic [ttc_pkg::TTC_AW-1:0]      wr_addr,
	output logic [ttc_pkg::TTC_DW-1:0]      wr_data,
	output logic                            rd_en,
	output logic [ttc_pkg::TTC_AW-1:0]      rd_addr
);
	import ttc_pkg::*;

	localparam logic [TTC_CW-1:0] DEPTH_C = TTC_CW'(TTC_DEPTH);
	localparam logic [TTC_AW-1:0] LAST_C  = TTC_AW'(TTC_DEPTH - 1);

	logic [TTC_CW-1:0] held_q, held_n;
	logic [TTC_AW-1:0] wp_q, wp_n;
	logic [TTC_AW-1:0] tp_q, tp_n;
	logic              armed_q, armed_n;
	logic              trig_q, trig_n;
	logic              accept;
	logic              at_trig, past_end;
	logic [TTC_CW-1:0] trig_dist;
	logic [TTC_CW:0]   pos;
	logic [TTC_CW:0]   ridx_w;
	ttc_stage_t        stage_q;

	assign req_ready = !stage_q.valid || take_s1;
	assign accept    = req_valid && req_ready;
	assign stage_s1  = stage_q;
	assign wr_data   = sample_value;
	assign ridx_w    = (TTC_CW+1)'(read_index);

	always_comb begin
		held_n    = held_q;
		wp_n      = wp_q;
		tp_n      = tp_q;
		armed_n   = armed_q;
		trig_n    = trig_q;
		at_trig   = 1'b0;
		past_end  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = wp_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		trig_dist = '0;
		pos       = '0;
		unique case (action)
			ACT_ARM: begin
				armed_n = 1'b1;
				trig_n  = 1'b0;
				held_n  = '0;
				wp_n    = '0;
			end
			ACT_SAMPLE: begin
				if (armed_q) begin
					wr_en = accept;
					wp_n  = (wp_q == LAST_C) ? '0 : wp_q + 1'b1;
					if (held_q < DEPTH_C) begin
						held_n = held_q + 1'b1;
					end
					if (trig_q) begin
						if (wp_n >= tp_q) begin
							trig_dist = TTC_CW'(wp_n) - TTC_CW'(tp_q);
						end else begin
							trig_dist = TTC_CW'(wp_n) + DEPTH_C - TTC_CW'(tp_q);
						end
						if (trig_dist == '0) begin
							trig_dist = DEPTH_C;
						end
						if (TTC_PW'(trig_dist) >= post_trigger_samples) begin
							armed_n = 1'b0;
						end
					end
				end
			end
			ACT_TRIGGER: begin
				trig_n = 1'b1;
				tp_n   = wp_q;
			end
			ACT_READ: begin
				armed_n = 1'b0;
				if (read_index >= TTC_IW'(held_q) || ridx_w >= (TTC_CW+1)'(TTC_DEPTH)) begin
					past_end = 1'b1;
					armed_n  = 1'b1;
					trig_n   = 1'b0;
					held_n   = '0;
					wp_n     = '0;
				end else begin
					pos = ridx_w + (TTC_CW+1)'(wp_q);
					if (pos >= (TTC_CW+1)'(held_q)) begin
						pos = pos - (TTC_CW+1)'(held_q);
					end
					if (pos >= (TTC_CW+1)'(TTC_DEPTH)) begin
						pos = pos - (TTC_CW+1)'(TTC_DEPTH);
					end
					rd_en   = accept;
					rd_addr = pos[TTC_AW-1:0];
					at_trig = trig_q && (pos[TTC_AW-1:0] == tp_q);
				end
			end
			default: begin
				armed_n = armed_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			wp_q    <= '0;
			tp_q    <= '0;
			armed_q <= 1'b1;
			trig_q  <= 1'b0;
			stage_q <= '0;
		end else begin
			if (accept) begin
				held_q  <= held_n;
				wp_q    <= wp_n;
				tp_q    <= tp_n;
				armed_q <= armed_n;
				trig_q  <= trig_n;
			end
			if (accept) begin
				stage_q.valid    <= 1'b1;
				stage_q.is_read  <= (action == ACT_READ) && !past_end;
				stage_q.done     <= !armed_n;
				stage_q.at_trig  <= at_trig;
				stage_q.past_end <= past_end;
				stage_q.held     <= held_n;
				stage_q.trig     <= trig_n;
			end else if (take_s1) begin
				stage_q.valid <= 1'b0;
			end
		end
	end

endmodule

// ----- design/ttc_out.sv -----
// Result register: merges store read data with the stage fields and drives the result stream.
module ttc_out (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ttc_pkg::ttc_stage_t             stage_s1,
	input  logic [ttc_pkg::TTC_DW-1:0]      rd_data,
	output logic                            take_s1,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ttc_pkg::TTC_OUT_TW-1:0]  m_tdata
);
	import ttc_pkg::*;

	localparam int unsigned PAY_W = 4 + TTC_DW + TTC_CW;

	logic              valid_q;
	logic [PAY_W-1:0]  data_q;
	logic [TTC_DW-1:0] rdata;

	assign take_s1  = stage_s1.valid && (!valid_q || m_tready);
	assign rdata    = stage_s1.is_read ? rd_data : '0;
	assign m_tvalid = valid_q;
	assign m_tdata  = TTC_OUT_TW'(data_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_s1) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			data_q <= {stage_s1.trig, stage_s1.held, stage_s1.past_end,
				stage_s1.at_trig, rdata, stage_s1.done};
		end
	end

endmodule

// ----- design/triggered_trace_capture_unit.sv -----
// Top level of the triggered trace capture unit: register port, control, store and result stage.
//
// Requests enter on the s_ stream: s_tuser carries the action (arm, sample, trigger,
// read), s_tdata the sample value and the chronological read index. Each request
// gives exactly one result on the m_ stream with the done flag, the read sample, the
// at-trigger and past-end flags, the held count and the triggered flag.
// The sample store is a 128 x 10 one-port-write, registered-read RAM; an accepted
// request addresses the RAM at once, and its result passes the first-stage register
// and the result register before it is valid on m_. One request per cycle is
// sustained while m_ is not stalled, bounded by the single RAM access per request.
// A stalled m_ side holds the result register; one more request may sit in the
// first stage, after which s_tready drops until the result is taken.
// Reset arms capture with empty pointers and count, loads the post-trigger count
// with 50, and leaves the store contents undefined; only entries written since the
// last arm are read back.
// The APB port holds post_trigger_samples at address 0; pready is always high.
module triggered_trace_capture_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ttc_pkg::TTC_IN_TW-1:0]       s_tdata,  // sample_value, read_index, pad
	input  logic [1:0]                          s_tuser,  // action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ttc_pkg::TTC_OUT_TW-1:0]      m_tdata,  // capture_done, read_data,
	                                                      // read_at_trigger, read_past_end,
	                                                      // points_held, is_triggered, pad
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ttc_pkg::TTC_PAW-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import ttc_pkg::*;

	logic [TTC_PW-1:0] pts_q;
	ttc_stage_t        stage_s1;
	logic              take_s1;
	logic              wr_en, rd_en;
	logic [TTC_AW-1:0] wr_addr, rd_addr;
	logic [TTC_DW-1:0] wr_data, rd_data;
	ttc_action_t       action;

	assign pready = 1'b1;
	assign prdata = (paddr == TTC_ADDR_PTS) ? 32'(pts_q) : '0;
	assign action = ttc_action_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= TTC_PTS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == TTC_ADDR_PTS) begin
			pts_q <= pwdata[TTC_PW-1:0];
		end
	end

	ttc_ctrl u_ctrl (
		.clk                  (clk),
		.arst_n               (arst_n),
		.req_valid            (s_tvalid),
		.req_ready            (s_tready),
		.action               (action),
		.sample_value         (s_tdata[TTC_DW-1:0]),
		.read_index           (s_tdata[TTC_DW+TTC_IW-1:TTC_DW]),
		.post_trigger_samples (pts_q),
		.take_s1              (take_s1),
		.stage_s1             (stage_s1),
		.wr_en                (wr_en),
		.wr_addr              (wr_addr),
		.wr_data              (wr_data),
		.rd_en                (rd_en),
		.rd_addr              (rd_addr)
	);

	ttc_ram #(
		.WIDTH (TTC_DW),
		.DEPTH (TTC_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ttc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.rd_data  (rd_data),
		.take_s1  (take_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
